// ===== hw/rtl/nsc_pkg.sv =====
`default_nettype none

package nsc_pkg;

  localparam int MAX_SAMPLES_DEF = 64;
  localparam int NUM_CLASSES_DEF = 16;
  localparam int RADIUS_RESET    = 10;
  localparam int RADIUS_W        = 9;
  localparam int DIST_W          = 18;

  typedef logic [2:0] op_t;

  localparam op_t OP_ADD       = 3'd0;
  localparam op_t OP_CLR_SMP   = 3'd1;
  localparam op_t OP_SET_COL   = 3'd2;
  localparam op_t OP_CLASSIFY  = 3'd3;
  localparam op_t OP_CLR_COL   = 3'd4;

  // One beat travelling down the sample chain.
  typedef struct packed {
    logic              vld;
    op_t               op;
    logic              ok;
    logic [3:0]        cls;    // class to store, or best class so far
    logic [7:0]        blue;
    logic [7:0]        green;
    logic [7:0]        red;
    logic [DIST_W-1:0] bound;  // current squared-distance bound
  } tok_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nsc_cell.sv =====
`default_nettype none

module nsc_cell import nsc_pkg::*; #(
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire tok_t             tok_in,
  input  wire logic [CNT_W-1:0] idx_in,
  output tok_t                  tok_out,
  output logic [CNT_W-1:0]      idx_out
);

  logic [7:0]        smp_blue;
  logic [7:0]        smp_green;
  logic [7:0]        smp_red;
  logic [3:0]        smp_cls;
  logic [15:0]       sq_b;
  logic [15:0]       sq_g;
  logic [15:0]       sq_r;
  logic [DIST_W-1:0] d2;
  logic              hit;
  logic              wr;
  tok_t              tok_next;

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

  assign sq_b = sq_diff(smp_blue, tok_in.blue);
  assign sq_g = sq_diff(smp_green, tok_in.green);
  assign sq_r = sq_diff(smp_red, tok_in.red);
  assign d2   = DIST_W'(sq_b) + DIST_W'(sq_g) + DIST_W'(sq_r);

  assign wr = en && tok_in.vld && (tok_in.op == OP_ADD) && tok_in.ok &&
              (idx_in == CNT_W'(IDX));

  always_comb begin
    hit = tok_in.vld && (tok_in.op == OP_CLASSIFY) && (idx_in > CNT_W'(IDX)) &&
          (d2 <= tok_in.bound);
    tok_next = tok_in;
    if (hit) begin
      tok_next.bound = d2;
      tok_next.cls   = smp_cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else if (en) begin
      tok_out <= tok_next;
      idx_out <= idx_in;
    end
  end

  // Capture the sample when its add beat passes this slot.
  always_ff @(posedge clk) begin
    if (wr) begin
      smp_blue  <= tok_in.blue;
      smp_green <= tok_in.green;
      smp_red   <= tok_in.red;
      smp_cls   <= tok_in.cls;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nsc_tail.sv =====
`default_nettype none

module nsc_tail import nsc_pkg::*; #(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire tok_t tok_in,
  output logic       out_valid,
  output logic [3:0] found_class,
  output logic [7:0] out_blue,
  output logic [7:0] out_green,
  output logic [7:0] out_red,
  output logic       ok
);

  localparam int CIW = $clog2(NUM_CLASSES);
  localparam int XW  = (CIW > 4) ? CIW : 4;

  logic [23:0]            col_mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] col_vld;
  logic [XW-1:0]          cls_x;
  logic [CIW-1:0]         cls_idx;
  logic                   in_range;
  logic [23:0]            rd_col;

  assign cls_x    = XW'(tok_in.cls);
  assign cls_idx  = cls_x[CIW-1:0];
  assign in_range = int'(tok_in.cls) < NUM_CLASSES;

  always_comb begin
    rd_col = 24'd0;
    if (in_range && col_vld[cls_idx]) begin
      rd_col = col_mem[cls_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      col_vld   <= '0;
    end else if (en) begin
      out_valid <= tok_in.vld;
      if (tok_in.vld && (tok_in.op == OP_SET_COL) && tok_in.ok) begin
        col_vld[cls_idx] <= 1'b1;
      end
      if (tok_in.vld && (tok_in.op == OP_CLR_COL)) begin
        col_vld <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && tok_in.vld && (tok_in.op == OP_SET_COL) && tok_in.ok) begin
      col_mem[cls_idx] <= {tok_in.red, tok_in.green, tok_in.blue};
    end
    if (en) begin
      ok <= tok_in.ok;
      if (tok_in.op == OP_CLASSIFY) begin
        found_class <= tok_in.cls;
        {out_red, out_green, out_blue} <= rd_col;
      end else begin
        found_class <= 4'd0;
        {out_red, out_green, out_blue} <= 24'd0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nearest_sample_color_classifier.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  opcode, class_id, blue, green, red
// out       output     out_valid/out_stall  found_class, out_blue, out_green, out_red, ok
// cfg       input      cfg_valid/cfg_ready  match_radius
//
// Every beat, whatever its opcode, walks the same chain of MAX_SAMPLES sample
// cells, one cell per cycle unless the output stalls, so operations keep their order
// without hazards. Beats pass the head register, the cells and the output register;
// one beat is taken per cycle unless stalled, set by the single shared chain advance.
// Reset clears the sample count, the class colour valid bits and all beat
// valid bits, and restores the radius to 10; no clearing pass is needed.
// A stalled output freezes the whole chain and stalls the input channel.

module nearest_sample_color_classifier import nsc_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          opcode,
  input  wire logic [3:0]          class_id,
  input  wire logic [7:0]          blue,
  input  wire logic [7:0]          green,
  input  wire logic [7:0]          red,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [3:0]               found_class,
  output logic [7:0]               out_blue,
  output logic [7:0]               out_green,
  output logic [7:0]               out_red,
  output logic                     ok,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [RADIUS_W-1:0] match_radius
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  logic              en;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [DIST_W-1:0] radius_sq;
  tok_t              head_tok;
  tok_t              head_beat;
  logic [CNT_W-1:0]  head_idx;
  tok_t              tok_chain [MAX_SAMPLES + 1];
  logic [CNT_W-1:0]  idx_chain [MAX_SAMPLES + 1];
  logic              cls_ok;
  logic              room;

  // Advance the whole chain unless a finished result is held at the output.
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // Keep the squared radius, so each cell compares squared distances directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_sq <= DIST_W'(RADIUS_RESET * RADIUS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      radius_sq <= DIST_W'(match_radius) * DIST_W'(match_radius);
    end
  end

  // Head: build the beat and keep the sample count in order with it.
  assign cls_ok = int'(class_id) < NUM_CLASSES;
  assign room   = count < CNT_W'(MAX_SAMPLES);

  always_comb begin
    count_next     = count;
    head_tok.vld   = in_valid;
    head_tok.op    = opcode;
    head_tok.ok    = 1'b1;
    head_tok.cls   = class_id;
    head_tok.blue  = blue;
    head_tok.green = green;
    head_tok.red   = red;
    head_tok.bound = radius_sq;
    case (opcode)
      OP_ADD: begin
        head_tok.ok = room && cls_ok;
        if (room && cls_ok) begin
          count_next = count + CNT_W'(1);
        end
      end
      OP_CLR_SMP: begin
        count_next = '0;
      end
      OP_SET_COL: begin
        head_tok.ok = cls_ok;
      end
      OP_CLASSIFY: begin
        // Start with no match: class 0 unless a cell improves on it.
        head_tok.cls = 4'd0;
      end
      OP_CLR_COL: begin
        head_tok.ok = 1'b1;
      end
      default: begin
        head_tok.ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      head_beat.vld <= 1'b0;
    end else if (en) begin
      head_beat <= head_tok;
      // Add beats carry their slot, classify beats the number of live slots.
      head_idx  <= count;
      if (in_valid) begin
        count <= count_next;
      end
    end
  end

  assign tok_chain[0] = head_beat;
  assign idx_chain[0] = head_idx;

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    nsc_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .tok_in  (tok_chain[i]),
      .idx_in  (idx_chain[i]),
      .tok_out (tok_chain[i+1]),
      .idx_out (idx_chain[i+1])
    );
  end

  nsc_tail #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_tail (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .tok_in      (tok_chain[MAX_SAMPLES]),
    .out_valid   (out_valid),
    .found_class (found_class),
    .out_blue    (out_blue),
    .out_green   (out_green),
    .out_red     (out_red),
    .ok          (ok)
  );

  // Hold: the sample count never passes the table size.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond table size");

  // Hold: nothing enters while a result waits at the output.
  a_no_accept_on_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output held");

  // Drop: an add into a full table leaves the count alone.
  a_full_add: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (opcode == OP_ADD) && (count == CNT_W'(MAX_SAMPLES))
    |=> $stable(count))
    else $error("count moved on add to full table");

  // A failed operation reports no class.
  a_fail_no_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> (found_class == 4'd0))
    else $error("class reported on failed operation");

endmodule

`default_nettype wire

// ===== verif/nearest_sample_color_classifier_tb.sv =====
`timescale 1ns / 100ps

module nearest_sample_color_classifier_tb;
  import nsc_pkg::*;

  localparam int LATENCY      = MAX_SAMPLES_DEF + 2;
  localparam int PHASE_ITEMS  = 155;
  localparam int NUM_PHASES   = 9;
  localparam int MAX_PRINTS   = 100;

  // Opcodes the block decodes as unused
  localparam op_t OP_RSVD5 = 3'd5;
  localparam op_t OP_RSVD6 = 3'd6;
  localparam op_t OP_RSVD7 = 3'd7;

  typedef struct packed {
    op_t        op;
    logic [3:0] cls;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_cmd_t;

  typedef struct packed {
    logic [3:0] found;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       ok;
  } label_t;

  // Block ports: every input starts at a known value
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [2:0]          opcode = '0;
  logic [3:0]          class_id = '0;
  logic [7:0]          blue = '0;
  logic [7:0]          green = '0;
  logic [7:0]          red = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [3:0]          found_class;
  logic [7:0]          out_blue;
  logic [7:0]          out_green;
  logic [7:0]          out_red;
  logic                ok;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [RADIUS_W-1:0] match_radius = '0;

  nearest_sample_color_classifier i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .class_id    (class_id),
    .blue        (blue),
    .green       (green),
    .red         (red),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found_class (found_class),
    .out_blue    (out_blue),
    .out_green   (out_green),
    .out_red     (out_red),
    .ok          (ok),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .match_radius(match_radius)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Commands waiting for the driver, and labels waiting for the block
  pixel_cmd_t pending_cmds[$];
  label_t     expected_labels[$];
  int         errors = 0;

  // Predictor state: sample table, class colour table, radius
  logic [23:0]         smp_colour [MAX_SAMPLES_DEF];
  logic [3:0]          smp_class  [MAX_SAMPLES_DEF];
  int                  smp_count = 0;
  logic [23:0]         class_colour [NUM_CLASSES_DEF];
  logic [RADIUS_W-1:0] radius_q = RADIUS_W'(RADIUS_RESET);

  // Generator shadow: colours of samples stored since the last clear
  logic [23:0] gen_colours[$];
  int          gen_count = 0;
  int          cur_radius = RADIUS_RESET;
  int          n_queued = 0;

  initial begin
    for (int i = 0; i < NUM_CLASSES_DEF; i++) class_colour[i] = '0;
  end

  task automatic report_error(input string msg);
    if (errors < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int unsigned sq_delta(input logic [7:0] a, input logic [7:0] b);
    int unsigned d;
    d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    return d * d;
  endfunction

  function automatic logic [3:0] rnd_cls();
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Update the table state for one accepted beat and queue its label
  task automatic classify_and_update(input pixel_cmd_t c);
    label_t      lbl;
    int unsigned bound;
    int unsigned d2;
    logic [23:0] s;
    lbl = '0;
    lbl.ok = 1'b1;
    case (c.op)
      OP_ADD: begin
        if (smp_count >= MAX_SAMPLES_DEF || c.cls >= NUM_CLASSES_DEF) begin
          lbl.ok = 1'b0;
        end else begin
          smp_colour[smp_count] = {c.red, c.green, c.blue};
          smp_class[smp_count]  = c.cls;
          smp_count++;
        end
      end
      OP_CLR_SMP: smp_count = 0;
      OP_SET_COL: begin
        if (c.cls >= NUM_CLASSES_DEF) lbl.ok = 1'b0;
        else class_colour[c.cls] = {c.red, c.green, c.blue};
      end
      OP_CLASSIFY: begin
        // Scan in insertion order; "<=" lets the later of equal samples win
        bound = int'(radius_q) * int'(radius_q);
        for (int i = 0; i < smp_count; i++) begin
          s  = smp_colour[i];
          d2 = sq_delta(s[7:0], c.blue) + sq_delta(s[15:8], c.green)
             + sq_delta(s[23:16], c.red);
          if (d2 <= bound) begin
            bound     = d2;
            lbl.found = smp_class[i];
          end
        end
        {lbl.red, lbl.green, lbl.blue} = class_colour[lbl.found];
      end
      OP_CLR_COL: begin
        for (int i = 0; i < NUM_CLASSES_DEF; i++) class_colour[i] = '0;
      end
      default: lbl.ok = 1'b0;
    endcase
    expected_labels.push_back(lbl);
  endtask

  // Driver: bursts of random length separated by random gaps; the payload
  // holds while stalled and the next beat goes out on the acceptance edge.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_cmds
    pixel_cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) classify_and_update({opcode, class_id, blue, green, red});
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        opcode   <= c.op;
        class_id <= c.cls;
        blue     <= c.blue;
        green    <= c.green;
        red      <= c.red;
        in_valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // Mostly short bursts; now and then a long stretch with no gaps
          if ($urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(100, 300);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = $urandom_range(0, 6);
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: switch at random among several patterns
  int       stall_left = 0;
  int       stall_mode = 0;
  bit [2:0] stall_phase = '0;

  always @(posedge clk) begin : drive_stall
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(50, 300);
    end else begin
      stall_left--;
    end
    stall_phase++;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= (stall_phase >= 3'd5);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // Monitor: compare each accepted beat with the oldest expected label
  always @(posedge clk) begin : check_labels
    label_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_labels.size() == 0) begin
        report_error("result beat with no label expected");
      end else begin
        want = expected_labels.pop_front();
        if (found_class !== want.found)
          report_error($sformatf("found_class %0h, want %0h", found_class, want.found));
        if (out_blue !== want.blue)
          report_error($sformatf("out_blue %0h, want %0h", out_blue, want.blue));
        if (out_green !== want.green)
          report_error($sformatf("out_green %0h, want %0h", out_green, want.green));
        if (out_red !== want.red)
          report_error($sformatf("out_red %0h, want %0h", out_red, want.red));
        if (ok !== want.ok)
          report_error($sformatf("ok %0b, want %0b", ok, want.ok));
      end
    end
  end

  // Queue one command and keep the generator shadow of the sample table
  task automatic queue_cmd(input op_t op, input logic [3:0] cls, input logic [7:0] b,
                           input logic [7:0] g, input logic [7:0] r);
    pixel_cmd_t c;
    c = '{op: op, cls: cls, blue: b, green: g, red: r};
    pending_cmds.push_back(c);
    n_queued++;
    if (op == OP_ADD && gen_count < MAX_SAMPLES_DEF) begin
      gen_colours.push_back({r, g, b});
      gen_count++;
    end else if (op == OP_CLR_SMP) begin
      gen_colours.delete();
      gen_count = 0;
    end
  endtask

  function automatic logic [7:0] jitter(input logic [7:0] v, input int span);
    int x;
    x = int'(v) + int'($urandom_range(0, 2 * span)) - span;
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return x[7:0];
  endfunction

  // Classify a pixel: mostly on or near a stored sample, some anywhere
  task automatic queue_pixel();
    int          kind;
    int          span;
    logic [23:0] s;
    kind = $urandom_range(0, 9);
    if (gen_colours.size() == 0 || kind < 2) begin
      queue_cmd(OP_CLASSIFY, rnd_cls(), rnd_byte(), rnd_byte(), rnd_byte());
    end else begin
      s = gen_colours[$urandom_range(0, gen_colours.size() - 1)];
      span = (cur_radius < 24) ? cur_radius + 1 : 24;
      if (kind < 4)
        queue_cmd(OP_CLASSIFY, rnd_cls(), s[7:0], s[15:8], s[23:16]);
      else
        queue_cmd(OP_CLASSIFY, rnd_cls(), jitter(s[7:0], span),
                  jitter(s[15:8], span), jitter(s[23:16], span));
    end
  endtask

  // Add n samples; some repeat an existing colour under a random class
  task automatic queue_samples(input int n);
    logic [23:0] s;
    repeat (n) begin
      if (gen_colours.size() > 0 && $urandom_range(0, 3) == 0) begin
        s = gen_colours[$urandom_range(0, gen_colours.size() - 1)];
        queue_cmd(OP_ADD, rnd_cls(), s[7:0], s[15:8], s[23:16]);
      end else begin
        queue_cmd(OP_ADD, rnd_cls(), rnd_byte(), rnd_byte(), rnd_byte());
      end
    end
  endtask

  // Hold until the driver is empty and every label has come back
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_valid || expected_labels.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_radius(input logic [RADIUS_W-1:0] v);
    @(posedge clk);
    cfg_valid    <= 1'b1;
    match_radius <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    radius_q   = v;
    cur_radius = int'(v);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int radius_plan [NUM_PHASES];
    int phase_start;
    int pick;
    int n;
    radius_plan = '{0, 442, 511, 1, 3, 255, 0, 10, 0};
    radius_plan[6] = $urandom_range(2, 60);
    radius_plan[8] = $urandom_range(0, 442);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset radius of 10
    queue_cmd(OP_CLASSIFY, 4'h0, 8'h00, 8'h00, 8'h00);   // empty table
    queue_cmd(OP_SET_COL,  4'h0, 8'hFF, 8'hFF, 8'hFF);
    queue_cmd(OP_SET_COL,  4'hF, 8'h00, 8'h80, 8'h7F);
    queue_cmd(OP_SET_COL,  4'h5, 8'hA5, 8'h5A, 8'h3C);
    queue_cmd(OP_CLASSIFY, 4'hF, 8'hFF, 8'hFF, 8'hFF);   // still empty: class 0 colour
    queue_cmd(OP_ADD,      4'hF, 8'hFF, 8'hFF, 8'hFF);
    queue_cmd(OP_ADD,      4'h5, 8'h00, 8'h00, 8'h00);
    queue_cmd(OP_ADD,      4'h0, 8'h80, 8'h80, 8'h80);
    queue_cmd(OP_CLASSIFY, 4'h0, 8'hFF, 8'hFF, 8'hFF);
    queue_cmd(OP_CLASSIFY, 4'h0, 8'h00, 8'h00, 8'h00);
    queue_cmd(OP_CLASSIFY, 4'h0, 8'd10, 8'd0, 8'd0);     // exactly on the radius
    queue_cmd(OP_CLASSIFY, 4'h0, 8'd6, 8'd8, 8'd0);      // on the radius, two axes
    queue_cmd(OP_CLASSIFY, 4'h0, 8'd11, 8'd0, 8'd0);     // just outside
    queue_cmd(OP_CLASSIFY, 4'h0, 8'd7, 8'd7, 8'd1);      // just inside
    queue_cmd(OP_ADD,      4'h3, 8'h00, 8'h00, 8'h00);   // duplicate colour
    queue_cmd(OP_CLASSIFY, 4'h0, 8'h00, 8'h00, 8'h00);   // later sample wins the tie
    queue_cmd(OP_RSVD5,    4'hA, 8'h55, 8'hAA, 8'h0F);
    queue_cmd(OP_RSVD6,    4'h5, 8'hAA, 8'h55, 8'hF0);
    queue_cmd(OP_RSVD7,    4'hF, 8'hFF, 8'hFF, 8'hFF);
    queue_cmd(OP_CLR_COL,  4'h7, 8'h12, 8'h34, 8'h56);
    queue_cmd(OP_CLASSIFY, 4'h0, 8'h00, 8'h00, 8'h00);   // match, colour now zero
    queue_cmd(OP_CLR_SMP,  4'h9, 8'h9A, 8'hBC, 8'hDE);
    queue_cmd(OP_CLASSIFY, 4'h0, 8'h00, 8'h00, 8'h00);   // cleared: no match
    queue_cmd(OP_ADD,      4'h9, 8'd1, 8'd2, 8'd3);      // overwrite slot 0
    queue_cmd(OP_CLASSIFY, 4'h0, 8'd1, 8'd2, 8'd3);
    wait_idle();

    // Random phases, one radius each; the first fills the table past full
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_radius(RADIUS_W'(radius_plan[p]));
      phase_start = n_queued;
      while (n_queued - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 70 || n_queued == phase_start) begin
          if ($urandom_range(0, 1) == 1)
            queue_cmd(OP_CLR_SMP, rnd_cls(), rnd_byte(), rnd_byte(), rnd_byte());
          if (p == 0 && n_queued - phase_start < 2)
            n = MAX_SAMPLES_DEF + 6;
          else if ($urandom_range(0, 7) == 0)
            n = $urandom_range(40, 70);
          else
            n = $urandom_range(1, 12);
          queue_samples(n);
          repeat ($urandom_range(0, 4))
            queue_cmd(OP_SET_COL, rnd_cls(), rnd_byte(), rnd_byte(), rnd_byte());
          repeat ($urandom_range(4, 16)) queue_pixel();
        end else if (pick < 80) begin
          queue_cmd(OP_CLR_COL, rnd_cls(), rnd_byte(), rnd_byte(), rnd_byte());
          repeat ($urandom_range(2, 8)) queue_pixel();
        end else begin
          // Noise: any opcode, any fields
          repeat ($urandom_range(3, 10))
            queue_cmd(op_t'($urandom_range(0, 7)), rnd_cls(), rnd_byte(),
                      rnd_byte(), rnd_byte());
        end
      end
      // Pause the sender until the block has returned every label
      wait_idle();
    end

    // Let any stray beat show up before the verdict
    repeat (2 * LATENCY + 20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
